>>> hw/rtl/isa16_pkg.sv
// Shared types and constants for the isa16 execute unit
`timescale 1ns / 1ps
package isa16_pkg;
  localparam logic [4:0] OP_ADD  = 5'b00000;
  localparam logic [4:0] OP_SUB  = 5'b00001;
  localparam logic [4:0] OP_AND  = 5'b00010;
  localparam logic [4:0] OP_NOR  = 5'b00011;
  localparam logic [4:0] OP_DIV  = 5'b00100;
  localparam logic [4:0] OP_MUL  = 5'b00101;
  localparam logic [4:0] OP_MOD  = 5'b00110;
  localparam logic [4:0] OP_POW  = 5'b00111;
  localparam logic [4:0] OP_LW   = 5'b01000;
  localparam logic [4:0] OP_SW   = 5'b01001;
  localparam logic [4:0] OP_JR   = 5'b01100;
  localparam logic [4:0] OP_HALT = 5'b01101;
  localparam logic [4:0] OP_PUT  = 5'b01110;
  localparam logic [4:0] OP_LIZ  = 5'b10000;
  localparam logic [4:0] OP_LIS  = 5'b10001;
  localparam logic [4:0] OP_LUI  = 5'b10010;
  localparam logic [4:0] OP_JALR = 5'b10011;
  localparam logic [4:0] OP_BP   = 5'b10100;
  localparam logic [4:0] OP_BN   = 5'b10101;
  localparam logic [4:0] OP_BX   = 5'b10110;
  localparam logic [4:0] OP_BZ   = 5'b10111;
  localparam logic [4:0] OP_J    = 5'b11000;

  localparam logic [1:0] UOP_MUL = 2'd0;
  localparam logic [1:0] UOP_DIV = 2'd1;
  localparam logic [1:0] UOP_MOD = 2'd2;
  localparam logic [1:0] UOP_POW = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  uop;
    logic [15:0] a;
    logic [15:0] b;
  } isa16_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] result;
  } isa16_rsp_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        print_valid;
    logic [15:0] print_value;
    logic        divide_error;
  } isa16_res_t;
endpackage

>>> hw/rtl/isa16_if.sv
// Valid/ready channel interfaces
`timescale 1ns / 1ps
interface isa16_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;
  modport source(output valid, output instr_word, input ready);
  modport sink(input valid, input instr_word, output ready);
endinterface

interface isa16_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       next_pc;
  logic              halted;
  logic              print_valid;
  logic signed [15:0] print_value;
  logic              divide_error;
  modport source(output valid, output next_pc, output halted, output print_valid,
                 output print_value, output divide_error, input ready);
  modport sink(input valid, input next_pc, input halted, input print_valid,
               input print_value, input divide_error, output ready);
endinterface

>>> hw/rtl/isa16_mdu.sv
// Iterative multiply, divide, modulo and power unit, one bit per cycle
`timescale 1ns / 1ps
module isa16_mdu (
  input  logic                  clk,
  input  logic                  rst,
  input  isa16_pkg::isa16_req_t req,
  output isa16_pkg::isa16_rsp_t rsp
);
  logic        busy;
  logic [4:0]  cnt;
  logic [1:0]  uop;
  logic [15:0] acc;
  logic [15:0] opb;
  logic [15:0] sq;
  logic [15:0] quo;
  logic [16:0] rem;
  logic        neg_q;
  logic        neg_r;
  logic        fin;
  logic [15:0] fin_val;
  logic [15:0] abs_a;
  logic [15:0] abs_b;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] pmul;

  assign abs_a  = req.a[15] ? 16'(-req.a) : req.a;
  assign abs_b  = req.b[15] ? 16'(-req.b) : req.b;
  assign rem_sh = {rem[15:0], quo[15]};
  assign rem_sub = rem_sh - {1'b0, opb};

  always_comb begin
    pmul = '0;
    if (uop == isa16_pkg::UOP_MUL) begin
      pmul = opb[0] ? 16'(acc + sq) : acc;
    end else if (uop == isa16_pkg::UOP_POW) begin
      pmul = opb[0] ? 16'(acc * sq) : acc;
    end
  end

  always_ff @(posedge clk) begin
    fin <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      uop  <= req.uop;
      acc  <= (req.uop == isa16_pkg::UOP_POW) ? 16'd1 : 16'd0;
      sq   <= req.a;
      opb  <= req.b;
      if (req.uop == isa16_pkg::UOP_DIV || req.uop == isa16_pkg::UOP_MOD) begin
        quo <= abs_a;
        opb <= abs_b;
      end
      rem   <= '0;
      neg_q <= req.a[15] ^ req.b[15];
      neg_r <= req.a[15];
      if (req.uop == isa16_pkg::UOP_POW && req.b[15]) begin
        busy <= 1'b0;
        fin  <= 1'b1;
        fin_val <= (req.a == 16'd1) ? 16'd1 :
                   (req.a == 16'hFFFF) ? (req.b[0] ? 16'hFFFF : 16'd1) : 16'd0;
      end
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      unique case (uop)
        isa16_pkg::UOP_MUL, isa16_pkg::UOP_POW: begin
          acc <= pmul;
          sq  <= (uop == isa16_pkg::UOP_MUL) ? {sq[14:0], 1'b0} : 16'(sq * sq);
          opb <= {1'b0, opb[15:1]};
          if (cnt == 5'd15) begin
            busy <= 1'b0;
            fin <= 1'b1;
            fin_val <= pmul;
          end
        end
        default: begin
          if (!rem_sub[16]) begin
            rem <= rem_sub;
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[14:0], 1'b0};
          end
          if (cnt == 5'd15) begin
            busy <= 1'b0;
            fin <= 1'b1;
            if (uop == isa16_pkg::UOP_DIV) begin
              fin_val <= neg_q ? 16'(-{quo[14:0], !rem_sub[16]})
                               : {quo[14:0], !rem_sub[16]};
            end else begin
              fin_val <= neg_r ? 16'(-(rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0]))
                               : (rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0]);
            end
          end
        end
      endcase
    end
  end

  assign rsp.done   = fin;
  assign rsp.result = fin_val;
endmodule

>>> hw/rtl/isa16_execute_unit_core.sv
// Top level: decode, register file, data memory and sequencer
// Simple instructions give a result the cycle after acceptance; lw first passes S_LW.
// mul, div, mod and pow run 16 steps of the shared unit, then S_MDU moves to S_OUT
// (pow with a negative exponent finishes without the steps).
// One instruction at a time; the next is taken only after its result is accepted.
// Synchronous reset clears registers, pc, halt flag and sequencer; memory undefined.
`timescale 1ns / 1ps
module isa16_execute_unit_core #(
  parameter int MEM_WORDS = 65536
) (
  input logic          clk,
  input logic          rst,
  isa16_in_if.sink     in_ch,
  isa16_out_if.source  out_ch
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MDU  = 2'd1;
  localparam logic [1:0] S_LW   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [15:0] regs [8];
  logic [15:0] pc;
  logic        halt;
  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;
  logic [2:0]  pend_rd;
  isa16_pkg::isa16_res_t res;
  isa16_pkg::isa16_req_t req;
  isa16_pkg::isa16_rsp_t rsp;

  logic [15:0] w;
  logic [4:0]  op;
  logic [2:0]  rd, rs, rt;
  logic [15:0] a, b, vd, npc;
  logic        acc;

  assign w  = in_ch.instr_word;
  assign op = w[15:11];
  assign rd = w[10:8];
  assign rs = w[7:5];
  assign rt = w[4:2];
  assign a  = regs[rs];
  assign b  = regs[rt];
  assign vd = regs[rd];
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    req.start = 1'b0;
    req.a = a;
    req.b = b;
    req.uop = isa16_pkg::UOP_MUL;
    if (acc && !halt) begin
      unique case (op)
        isa16_pkg::OP_MUL: begin req.start = 1'b1; req.uop = isa16_pkg::UOP_MUL; end
        isa16_pkg::OP_POW: begin req.start = 1'b1; req.uop = isa16_pkg::UOP_POW; end
        isa16_pkg::OP_DIV: begin
          req.start = (b != 16'd0); req.uop = isa16_pkg::UOP_DIV;
        end
        isa16_pkg::OP_MOD: begin
          req.start = (b != 16'd0); req.uop = isa16_pkg::UOP_MOD;
        end
        default: req.start = 1'b0;
      endcase
    end
  end

  isa16_mdu u_mdu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always_comb begin
    npc = 16'(pc + 16'd2);
    unique case (op)
      isa16_pkg::OP_JR:   npc = a & 16'hFFFE;
      isa16_pkg::OP_JALR: npc = ((rd == rs) ? 16'(pc + 16'd2) : a) & 16'hFFFE;
      isa16_pkg::OP_BP:   if (!vd[15] && vd != 16'd0) npc = {7'd0, w[7:0], 1'b0};
      isa16_pkg::OP_BN:   if (vd[15]) npc = {7'd0, w[7:0], 1'b0};
      isa16_pkg::OP_BX:   if (vd != 16'd0) npc = {7'd0, w[7:0], 1'b0};
      isa16_pkg::OP_BZ:   if (vd == 16'd0) npc = {7'd0, w[7:0], 1'b0};
      isa16_pkg::OP_J:    npc = {pc[15:12], w[10:0], 1'b0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && !halt && op == isa16_pkg::OP_SW) begin
      mem[a[AW-1:0]] <= b;
    end
    mem_q <= mem[a[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      halt  <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (acc) begin
          pend_rd <= rd;
          res <= '0;
          if (halt) begin
            res.next_pc <= pc;
            res.halted  <= 1'b1;
            state <= S_OUT;
          end else begin
            pc <= npc;
            res.next_pc <= npc;
            state <= S_OUT;
            unique case (op)
              isa16_pkg::OP_ADD: regs[rd] <= 16'(a + b);
              isa16_pkg::OP_SUB: regs[rd] <= 16'(a - b);
              isa16_pkg::OP_AND: regs[rd] <= a & b;
              isa16_pkg::OP_NOR: regs[rd] <= ~(a | b);
              isa16_pkg::OP_DIV, isa16_pkg::OP_MOD: begin
                if (b == 16'd0) begin
                  regs[rd] <= '0;
                  res.divide_error <= 1'b1;
                end else begin
                  state <= S_MDU;
                end
              end
              isa16_pkg::OP_MUL, isa16_pkg::OP_POW: state <= S_MDU;
              isa16_pkg::OP_LW:  state <= S_LW;
              isa16_pkg::OP_HALT: begin
                halt <= 1'b1;
                res.halted <= 1'b1;
              end
              isa16_pkg::OP_PUT: begin
                res.print_valid <= 1'b1;
                res.print_value <= a;
              end
              isa16_pkg::OP_LIZ: regs[rd] <= {8'd0, w[7:0]};
              isa16_pkg::OP_LIS: regs[rd] <= {{8{w[7]}}, w[7:0]};
              isa16_pkg::OP_LUI: regs[rd] <= {w[7:0], vd[7:0]};
              isa16_pkg::OP_JALR: regs[rd] <= 16'(pc + 16'd2);
              default: ;
            endcase
          end
        end
        S_MDU: if (rsp.done) begin
          regs[pend_rd] <= rsp.result;
          state <= S_OUT;
        end
        S_LW: begin
          regs[pend_rd] <= mem_q;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = (state == S_OUT);
  assign out_ch.next_pc      = res.next_pc;
  assign out_ch.halted       = res.halted;
  assign out_ch.print_valid  = res.print_valid;
  assign out_ch.print_value  = res.print_value;
  assign out_ch.divide_error = res.divide_error;
endmodule

>>> hw/rtl/isa16_checker.sv
// Port-level checks for the isa16 execute unit, bound to the top level
`timescale 1ns / 1ps
module isa16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] next_pc,
  input logic        halted,
  input logic        print_valid,
  input logic        divide_error
);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_pc_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !next_pc[0]) else $error("odd next_pc");
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !print_valid && !divide_error) else $error("halted with event");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc)) else $error("result dropped");
endmodule

bind isa16_execute_unit_core isa16_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .next_pc(out_ch.next_pc), .halted(out_ch.halted),
  .print_valid(out_ch.print_valid), .divide_error(out_ch.divide_error)
);
